### rtl/bpb_pkg.sv
// Shared types and constants of the bimodal branch predictor with target buffer.
package bpb_pkg;

  localparam int TargetSets     = 128;
  localparam int TargetWays     = 4;
  localparam int CounterEntries = 512;

  localparam int AddrW     = 64;
  localparam int SizeW     = 4;
  localparam int CfgW      = 4;
  localparam int CntW      = 8;
  localparam int SetW      = $clog2(TargetSets);
  localparam int WayW      = (TargetWays > 1) ? $clog2(TargetWays) : 1;
  localparam int TagW      = AddrW - 2 - SetW;
  localparam int StampW    = 32;
  localparam int LaneW     = 3;
  localparam int Lanes     = 1 << LaneW;
  localparam int CidxW     = $clog2(CounterEntries);
  localparam int CrowW     = CidxW - LaneW;
  localparam int CRows     = CounterEntries / Lanes;
  localparam int InDataW   = 136;
  localparam int InUserW   = 2;
  localparam int OutDataW  = 8;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(2);

  typedef struct packed {
    logic              vld;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } bpb_way_t;

  typedef bpb_way_t [TargetWays-1:0] bpb_row_t;

  typedef struct packed {
    logic load;
    logic commit;
  } bpb_cmd_t;

  // Counter maximum for a raw width setting, clamped to one to eight bits.
  function automatic logic [CntW-1:0] cnt_max(input logic [CfgW-1:0] bits);
    logic [CfgW-1:0] eff;
    eff = bits;
    if (bits == '0) eff = CfgW'(1);
    else if (bits > CfgW'(CntW)) eff = CfgW'(CntW);
    cnt_max = CntW'((9'd1 << eff) - 9'd1);
  endfunction

endpackage

### rtl/bpb_ctrl.sv
// Controller of the predictor: accepts words and sequences lookup and commit.
module bpb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output bpb_pkg::bpb_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   room;

  assign room       = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign cmd.load   = in_tvalid && (state_r == ST_IDLE);
  assign cmd.commit = (state_r == ST_EXEC) && room;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (room) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/bpb_dp.sv
// Datapath of the predictor: target buffer, counter table and result register.
module bpb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpb_pkg::bpb_cmd_t             cmd,
  input  logic [bpb_pkg::InDataW-1:0]   in_tdata,
  input  logic [bpb_pkg::InUserW-1:0]   in_tuser,
  input  logic                          cfg_valid,
  input  logic [bpb_pkg::CfgW-1:0]      cfg_data,
  output logic [bpb_pkg::OutDataW-1:0]  out_tdata
);

  localparam int AW = bpb_pkg::AddrW;

  logic [AW-1:0]                   addr_r, next_r;
  logic [bpb_pkg::SizeW-1:0]       size_r;
  logic                            br_r, cond_r;
  logic [bpb_pkg::CfgW-1:0]        bits_r;
  logic [bpb_pkg::StampW-1:0]      count_r;
  logic [bpb_pkg::TargetSets-1:0]  tvalid_r;
  logic [bpb_pkg::CRows-1:0]       cvalid_r;
  logic [bpb_pkg::OutDataW-1:0]    res_r;

  bpb_pkg::bpb_row_t                    tmem [bpb_pkg::TargetSets];
  logic [bpb_pkg::Lanes*bpb_pkg::CntW-1:0] cmem [bpb_pkg::CRows];
  bpb_pkg::bpb_row_t                    trow_q;
  logic [bpb_pkg::Lanes*bpb_pkg::CntW-1:0] crow_q;

  logic [AW-3:0]                   word, rd_word;
  logic [bpb_pkg::SetW-1:0]        set_idx;
  logic [bpb_pkg::TagW-1:0]        tag;
  logic [bpb_pkg::CrowW-1:0]       crow_idx;
  logic [bpb_pkg::LaneW-1:0]       lane;
  logic [bpb_pkg::StampW-1:0]      count_inc;
  bpb_pkg::bpb_row_t               ways, trow_new;
  logic [bpb_pkg::Lanes*bpb_pkg::CntW-1:0] crow, crow_new;
  logic                            hit, any_inv, have, taken, pred, stage;
  logic [bpb_pkg::WayW-1:0]        hit_way, vic;
  logic [bpb_pkg::StampW-1:0]      best;
  logic [bpb_pkg::CntW-1:0]        maxv, thr, cnt, cnt_new;

  assign rd_word   = in_tdata[AW-1:2];
  assign word      = addr_r[AW-1:2];
  assign set_idx   = word[bpb_pkg::SetW-1:0];
  assign tag       = word[AW-3:bpb_pkg::SetW];
  assign crow_idx  = word[bpb_pkg::CidxW-1:bpb_pkg::LaneW];
  assign lane      = word[bpb_pkg::LaneW-1:0];
  assign count_inc = count_r + 1'b1;
  assign maxv      = bpb_pkg::cnt_max(bits_r);
  assign thr       = maxv >> 1;
  assign taken     = (addr_r + {{(AW - bpb_pkg::SizeW){1'b0}}, size_r}) != next_r;
  assign ways      = tvalid_r[set_idx] ? trow_q : '0;
  assign crow      = cvalid_r[crow_idx] ? crow_q : {bpb_pkg::Lanes{thr}};
  assign cnt       = crow[lane*bpb_pkg::CntW +: bpb_pkg::CntW];
  assign out_tdata = res_r;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    vic     = '0;
    have    = 1'b0;
    best    = '0;
    for (int w = 0; w < bpb_pkg::TargetWays; w++) begin
      if (ways[w].vld && ways[w].tag == tag) begin
        hit     = 1'b1;
        hit_way = bpb_pkg::WayW'(w);
      end
      if (!ways[w].vld) begin
        any_inv = 1'b1;
        vic     = bpb_pkg::WayW'(w);
      end
    end
    if (!any_inv) begin
      for (int w = 0; w < bpb_pkg::TargetWays; w++) begin
        if (!have || ways[w].stamp <= best) begin
          best = ways[w].stamp;
          vic  = bpb_pkg::WayW'(w);
          have = 1'b1;
        end
      end
    end
    trow_new = ways;
    if (hit) begin
      trow_new[hit_way].stamp = count_inc;
    end else begin
      trow_new[vic].vld   = 1'b1;
      trow_new[vic].tag   = tag;
      trow_new[vic].stamp = count_inc;
    end
  end

  always_comb begin
    cnt_new = cnt;
    if (taken) begin
      if (cnt < maxv) cnt_new = cnt + 1'b1;
    end else begin
      if (cnt != '0) cnt_new = cnt - 1'b1;
    end
    crow_new = crow;
    crow_new[lane*bpb_pkg::CntW +: bpb_pkg::CntW] = cnt_new;
    pred  = (br_r && cond_r) ? (cnt >= thr) : taken;
    stage = 1'b0;
    if (br_r) begin
      stage = hit ? (cond_r && (pred != taken)) : taken;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trow_q <= tmem[rd_word[bpb_pkg::SetW-1:0]];
      crow_q <= cmem[rd_word[bpb_pkg::CidxW-1:bpb_pkg::LaneW]];
    end
    if (cmd.commit && br_r) begin
      tmem[set_idx] <= trow_new;
      if (cond_r) cmem[crow_idx] <= crow_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_tdata[AW-1:0];
      size_r <= in_tdata[AW +: bpb_pkg::SizeW];
      next_r <= in_tdata[AW + bpb_pkg::SizeW +: AW];
      br_r   <= in_tuser[0];
      cond_r <= in_tuser[1];
    end
    if (cmd.commit) begin
      res_r <= {4'b0, taken, pred, hit && br_r, stage};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= bpb_pkg::CfgReset;
      count_r  <= '0;
      tvalid_r <= '0;
      cvalid_r <= '0;
    end else begin
      if (cfg_valid) begin
        bits_r   <= cfg_data;
        cvalid_r <= '0;
      end else if (cmd.commit && br_r && cond_r) begin
        cvalid_r[crow_idx] <= 1'b1;
      end
      if (cmd.commit && br_r) begin
        count_r           <= count_inc;
        tvalid_r[set_idx] <= 1'b1;
      end
    end
  end

endmodule

### rtl/bimodal_predictor_with_btb_core.sv
// Top level of the bimodal branch predictor with set-associative target buffer.
// For each input word the target buffer row and the counter row are first read from
// their memories; once the output register has room, tags are compared, the counter is
// trained and, for branches, both rows are written back (the counter row only for
// conditional ones). A further word is accepted once the previous result has entered
// the output register. Valid bits kept per row stand in for clearing, so no clearing
// pass follows reset, and a counter width write reloads all counters at once.
module bimodal_predictor_with_btb_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // branch_address, instr_size, next_address, zero padding
  input  logic [bpb_pkg::InDataW-1:0]  in_tdata,
  // is_branch, is_cond
  input  logic [bpb_pkg::InUserW-1:0]  in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // resolve_stage, target_hit, predicted_taken, actual_taken, zero padding
  output logic [bpb_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpb_pkg::CfgW-1:0]     cfg_data
);

  bpb_pkg::bpb_cmd_t cmd;

  assign cfg_ready = 1'b1;

  bpb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bpb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata)
  );

endmodule
